// ===== rtl/qse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qse_pkg
// Shared widths, payload constants and static-table lookups for the QPACK
// :status extractor.
// ----------------------------------------------------------------------------
package qse_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 31;
    localparam int INT_W    = 64;
    localparam int DIGIT_W  = 32;
    localparam int STNUM_W  = 9;

    localparam logic [STATUS_W-1:0] ACCEPT_RESET = 31'd233;
    localparam logic [2:0]          NAME_LEN     = 3'd7;

    // characters of ":status" by position
    function automatic logic [BYTE_W-1:0] name_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h3A;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h74;
            3'd5:    c = 8'h75;
            3'd6:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // static table entries that carry a fixed :status value, 0 for none
    function automatic logic [STNUM_W-1:0] static_status(input logic [INT_W-1:0] idx);
        logic [STNUM_W-1:0] s;
        s = '0;
        if (idx[INT_W-1:7] == '0)
        begin
            case (idx[6:0])
                7'd24:   s = 9'd103;
                7'd25:   s = 9'd200;
                7'd26:   s = 9'd304;
                7'd27:   s = 9'd404;
                7'd28:   s = 9'd503;
                7'd63:   s = 9'd100;
                7'd64:   s = 9'd204;
                7'd65:   s = 9'd206;
                7'd66:   s = 9'd302;
                7'd67:   s = 9'd400;
                7'd68:   s = 9'd403;
                7'd69:   s = 9'd421;
                7'd70:   s = 9'd425;
                7'd71:   s = 9'd500;
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    // every :status entry has a nonzero value, so the name test follows
    function automatic logic name_is_status(input logic [INT_W-1:0] idx);
        return static_status(idx) != '0;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qse_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qse_in_if
// Field-section byte channel: one byte per beat, last marks the final byte.
// ----------------------------------------------------------------------------
interface qse_in_if;
    logic                       valid;
    logic                       ready;
    logic [qse_pkg::BYTE_W-1:0] data_byte;
    logic                       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/qse_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qse_out_if
// Status report channel: one beat per field section.
// ----------------------------------------------------------------------------
interface qse_out_if;
    logic                         valid;
    logic                         ready;
    logic                         status_found;
    logic [qse_pkg::STATUS_W-1:0] status_value;
    logic                         accepted;

    modport source (output valid, output status_found, output status_value,
                    output accepted, input ready);
    modport sink   (input valid, input status_found, input status_value,
                    input accepted, output ready);
endinterface
`default_nettype wire

// ===== rtl/qpack_status_extractor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpack_status_extractor
// Parses a QPACK field section byte by byte and reports the :status value
// on the last byte of the section.
//
//   channel   | dir | payload                                | beats
//   ----------+-----+----------------------------------------+-----------------
//   section   | in  | data_byte[7:0], last                   | one per byte
//   report    | out | status_found, status_value[30:0], acc. | one per section
//   cfg       | in  | cfg_wr_en, cfg_wr_data[30:0]           | accept_status
//
// One byte per cycle; each byte is decoded combinationally into the next values of the parse
// registers (prefix integers, up to two Huffman digits, digit accumulator).
// The report beat appears the cycle after the last byte is taken.
// Input stalls only while a report beat is held and report.ready is low.
// Reset clears the parse state; accept_status resets to 233.
// ----------------------------------------------------------------------------
module qpack_status_extractor #(
    parameter int LENGTH_BITS = 32
) (
    input  wire                           clk,
    input  wire                           rst_n,
    qse_in_if.sink                        section,
    qse_out_if.source                     report,
    input  wire                           cfg_wr_en,
    input  wire [qse_pkg::STATUS_W-1:0]   cfg_wr_data
);
    import qse_pkg::*;

    typedef enum logic [3:0] {
        PH_RIC_FIRST,
        PH_RIC_CONT,
        PH_BASE_FIRST,
        PH_BASE_CONT,
        PH_LINE,
        PH_IDX_CONT,
        PH_NREF_CONT,
        PH_VLEN_FIRST,
        PH_VLEN_CONT,
        PH_VAL_BODY,
        PH_NLEN_CONT,
        PH_NAME_BODY
    } phase_t;

    localparam logic [INT_W-1:0] LEN_MAX = (LENGTH_BITS >= INT_W) ? {INT_W{1'b1}} :
        ((64'd1 << LENGTH_BITS) - 64'd1);

    phase_t                 phase_reg, phase_next;
    logic [INT_W-1:0]       acc_reg, acc_next;
    logic [6:0]             shift_reg, shift_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic                   huff_reg, huff_next;
    logic [3:0]             bits_reg, bits_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]     digit_reg, digit_next;
    logic                   dvalid_reg, dvalid_next;
    logic [2:0]             pos_reg, pos_next;
    logic                   match_reg, match_next;
    logic                   sref_reg, sref_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   found_reg, found_next;
    logic                   halted_reg, halted_next;
    logic [STATUS_W-1:0]    accept_reg;

    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [STATUS_W-1:0]    out_value_reg;
    logic                   out_acc_reg;

    logic                   take;
    logic [BYTE_W-1:0]      b;

    // integer step
    logic [INT_W-1:0]       int_val;
    logic                   int_go;
    phase_t                 int_tgt;
    logic [STNUM_W-1:0]     st_val;

    // Huffman two-digit lookahead
    logic [11:0]            hbuf, hbuf1, hbuf2, mask1, mask2;
    logic [3:0]             hc, c1, c2;
    logic [4:0]             v1, v2;
    logic                   full1, full2;
    logic [DIGIT_W-1:0]     dig1, dig2, dig_plain;

    // body control
    logic [LENGTH_BITS-1:0] bl;
    logic                   last_str, need2, end_ok;

    assign section.ready = !out_valid_reg || report.ready;
    assign take          = section.valid && section.ready;
    assign b             = section.data_byte;

    assign report.valid        = out_valid_reg;
    assign report.status_found = out_found_reg;
    assign report.status_value = out_value_reg;
    assign report.accepted     = out_acc_reg;

    assign st_val = static_status(int_val);

    always_comb
    begin
        hbuf  = {bits_reg, b};
        hc    = {1'b0, cnt_reg} + 4'd8;
        c1    = hc - 4'd5;
        v1    = 5'(hbuf >> (hc - 4'd5));
        mask1 = (12'd1 << c1) - 12'd1;
        hbuf1 = hbuf & mask1;
        c2    = c1 - 4'd5;
        v2    = 5'(hbuf1 >> c2);
        mask2 = (12'd1 << c2) - 12'd1;
        hbuf2 = hbuf1 & mask2;
        full1 = (hbuf1 == mask1);
        full2 = (hbuf2 == mask2);
        dig1  = (digit_reg << 3) + (digit_reg << 1) + DIGIT_W'(v1);
        dig2  = (dig1 << 3) + (dig1 << 1) + DIGIT_W'(v2);
        dig_plain = (digit_reg << 3) + (digit_reg << 1) + DIGIT_W'(b[3:0]);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        huff_next   = huff_reg;
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        digit_next  = digit_reg;
        dvalid_next = dvalid_reg;
        pos_next    = pos_reg;
        match_next  = match_reg;
        sref_next   = sref_reg;
        status_next = status_reg;
        found_next  = found_reg;
        halted_next = halted_reg;
        int_val     = '0;
        int_go      = 1'b0;
        int_tgt     = phase_reg;
        bl          = left_reg - LENGTH_BITS'(1);
        last_str    = (bl == '0);
        need2       = 1'b0;
        end_ok      = 1'b0;

        if (take && !halted_reg)
        begin
            case (phase_reg)
                PH_RIC_FIRST:
                begin
                    int_val    = INT_W'(b);
                    int_go     = (b != 8'hFF);
                    int_tgt    = PH_RIC_CONT;
                    phase_next = PH_RIC_CONT;
                    shift_next = '0;
                    acc_next   = int_val;
                end
                PH_BASE_FIRST:
                begin
                    int_val    = INT_W'(b[6:0]);
                    int_go     = (b[6:0] != 7'h7F);
                    int_tgt    = PH_BASE_CONT;
                    phase_next = PH_BASE_CONT;
                    shift_next = '0;
                    acc_next   = int_val;
                end
                PH_LINE:
                begin
                    shift_next = '0;
                    if (b[7])
                    begin
                        sref_next  = b[6];
                        int_val    = INT_W'(b[5:0]);
                        int_go     = (b[5:0] != 6'h3F);
                        int_tgt    = PH_IDX_CONT;
                        phase_next = PH_IDX_CONT;
                        acc_next   = int_val;
                    end
                    else if (b[6])
                    begin
                        sref_next  = b[4];
                        int_val    = INT_W'(b[3:0]);
                        int_go     = (b[3:0] != 4'hF);
                        int_tgt    = PH_NREF_CONT;
                        phase_next = PH_NREF_CONT;
                        acc_next   = int_val;
                    end
                    else if (b[5])
                    begin
                        huff_next  = b[3];
                        int_val    = INT_W'(b[2:0]);
                        int_go     = (b[2:0] != 3'h7);
                        int_tgt    = PH_NLEN_CONT;
                        phase_next = PH_NLEN_CONT;
                        acc_next   = int_val;
                    end
                    else
                    begin
                        // post-base or dynamic line
                        halted_next = 1'b1;
                    end
                end
                PH_VLEN_FIRST:
                begin
                    huff_next  = b[7];
                    int_val    = INT_W'(b[6:0]);
                    int_go     = (b[6:0] != 7'h7F);
                    int_tgt    = PH_VLEN_CONT;
                    phase_next = PH_VLEN_CONT;
                    shift_next = '0;
                    acc_next   = int_val;
                end
                PH_RIC_CONT, PH_BASE_CONT, PH_IDX_CONT,
                PH_NREF_CONT, PH_VLEN_CONT, PH_NLEN_CONT:
                begin
                    int_val    = acc_reg + (INT_W'(b[6:0]) << shift_reg[5:0]);
                    acc_next   = int_val;
                    shift_next = shift_reg + 7'd7;
                    if (!b[7])
                    begin
                        int_go = 1'b1;
                    end
                    else if (shift_next > 7'd63)
                    begin
                        halted_next = 1'b1;
                    end
                end
                PH_VAL_BODY, PH_NAME_BODY:
                begin
                    left_next = bl;
                    if (!huff_reg)
                    begin
                        if (phase_reg == PH_VAL_BODY)
                        begin
                            if (b >= 8'h30 && b <= 8'h39)
                            begin
                                digit_next  = dig_plain;
                                dvalid_next = 1'b1;
                            end
                            else
                            begin
                                match_next = 1'b0;
                            end
                        end
                        else if (pos_reg < NAME_LEN && b == name_char(pos_reg))
                        begin
                            pos_next = pos_reg + 3'd1;
                        end
                        else
                        begin
                            match_next = 1'b0;
                        end
                        end_ok = last_str;
                    end
                    else
                    begin
                        // second code: more bytes follow, or end padding is not all ones
                        need2 = (c1 >= 4'd5) && (!last_str || !full1);
                        if (v1 > 5'd9 || (need2 && v2 > 5'd9))
                        begin
                            halted_next = 1'b1;
                        end
                        else if (last_str && !need2 && !full1)
                        begin
                            halted_next = 1'b1;
                        end
                        else if (last_str && need2 && !full2)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            if (phase_reg == PH_VAL_BODY)
                            begin
                                digit_next  = need2 ? dig2 : dig1;
                                dvalid_next = 1'b1;
                            end
                            else
                            begin
                                match_next = 1'b0;
                            end
                            bits_next = need2 ? hbuf2[3:0] : hbuf1[3:0];
                            cnt_next  = need2 ? c2[2:0] : c1[2:0];
                            end_ok    = last_str;
                        end
                    end
                    if (end_ok)
                    begin
                        if (phase_reg == PH_NAME_BODY)
                        begin
                            match_next = match_next && (pos_next == NAME_LEN);
                            phase_next = PH_VLEN_FIRST;
                        end
                        else
                        begin
                            if (match_next && dvalid_next)
                            begin
                                status_next = digit_next[STATUS_W-1:0];
                                found_next  = 1'b1;
                            end
                            phase_next = PH_LINE;
                        end
                    end
                end
                default:
                begin
                    halted_next = 1'b1;
                end
            endcase

            if (int_go)
            begin
                case (int_tgt)
                    PH_RIC_CONT:
                    begin
                        phase_next = PH_BASE_FIRST;
                    end
                    PH_BASE_CONT:
                    begin
                        phase_next = PH_LINE;
                    end
                    PH_IDX_CONT:
                    begin
                        if (sref_next && st_val != '0)
                        begin
                            status_next = STATUS_W'(st_val);
                            found_next  = 1'b1;
                        end
                        phase_next = PH_LINE;
                    end
                    PH_NREF_CONT:
                    begin
                        match_next = sref_next && name_is_status(int_val);
                        phase_next = PH_VLEN_FIRST;
                    end
                    default:
                    begin
                        // string length: value or literal name
                        if (int_val > LEN_MAX)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            left_next = int_val[LENGTH_BITS-1:0];
                            bits_next = '0;
                            cnt_next  = '0;
                            if (int_tgt == PH_VLEN_CONT)
                            begin
                                digit_next  = '0;
                                dvalid_next = 1'b0;
                                phase_next  = (int_val == '0) ? PH_LINE : PH_VAL_BODY;
                            end
                            else
                            begin
                                pos_next   = '0;
                                match_next = (int_val != '0);
                                phase_next = (int_val == '0) ? PH_VLEN_FIRST : PH_NAME_BODY;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIC_FIRST;
            acc_reg       <= '0;
            shift_reg     <= '0;
            left_reg      <= '0;
            huff_reg      <= 1'b0;
            bits_reg      <= '0;
            cnt_reg       <= '0;
            digit_reg     <= '0;
            dvalid_reg    <= 1'b0;
            pos_reg       <= '0;
            match_reg     <= 1'b0;
            sref_reg      <= 1'b0;
            status_reg    <= '0;
            found_reg     <= 1'b0;
            halted_reg    <= 1'b0;
            accept_reg    <= ACCEPT_RESET;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_value_reg <= '0;
            out_acc_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                accept_reg <= cfg_wr_data;
            end

            if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (take && section.last)
            begin
                out_valid_reg <= 1'b1;
                out_found_reg <= found_next;
                out_value_reg <= found_next ? status_next : '0;
                out_acc_reg   <= found_next && (status_next == accept_reg);
                // section done: parse state back to start
                phase_reg  <= PH_RIC_FIRST;
                acc_reg    <= '0;
                shift_reg  <= '0;
                left_reg   <= '0;
                huff_reg   <= 1'b0;
                bits_reg   <= '0;
                cnt_reg    <= '0;
                digit_reg  <= '0;
                dvalid_reg <= 1'b0;
                pos_reg    <= '0;
                match_reg  <= 1'b0;
                sref_reg   <= 1'b0;
                status_reg <= '0;
                found_reg  <= 1'b0;
                halted_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                shift_reg  <= shift_next;
                left_reg   <= left_next;
                huff_reg   <= huff_next;
                bits_reg   <= bits_next;
                cnt_reg    <= cnt_next;
                digit_reg  <= digit_next;
                dvalid_reg <= dvalid_next;
                pos_reg    <= pos_next;
                match_reg  <= match_next;
                sref_reg   <= sref_next;
                status_reg <= status_next;
                found_reg  <= found_next;
                halted_reg <= halted_next;
            end
        end
    end

    a_acc_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid |-> (!report.accepted || report.status_found))
        else $error("accepted without a found status");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (report.valid && !report.status_found) |-> (report.status_value == '0))
        else $error("status value nonzero with no status found");

    a_last_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (take && section.last) |=> (report.valid && phase_reg == PH_RIC_FIRST))
        else $error("last beat did not produce a report");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg && !(take && section.last)) |=> halted_reg)
        else $error("halt released before end of section");

endmodule
`default_nettype wire
